// File: src/grid_neighbor_index_generator_assert.svh
// ----------------------------------------------------------------------------
// Grid neighbour index generator - assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GRID_NEIGHBOR_INDEX_GENERATOR_ASSERT_SVH
`define GRID_NEIGHBOR_INDEX_GENERATOR_ASSERT_SVH

// same-cycle implication
`define GNIG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GNIG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/gnig_pkg.sv
// ----------------------------------------------------------------------------
// Grid neighbour index generator - package
// Widths, codes, neighbour offset tables and small helper functions.
// ----------------------------------------------------------------------------
package gnig_pkg;

  localparam int IDX_W       = 30;
  localparam int DIM_W       = 11;
  localparam int SLICE_W     = 2 * DIM_W;
  localparam int VOL_W       = 3 * DIM_W;
  localparam int OFS_W       = VOL_W + 2;
  localparam int STEP_N      = 2;
  localparam int DIV_STAGES  = IDX_W / STEP_N;
  localparam int SLOT_N      = 26;
  localparam int SLOT_W      = 5;
  localparam int FACE_N      = 6;
  localparam int FACE_W      = 3;
  localparam int CFG_ADDR_W  = 3;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_TUSER_W = 3;

  localparam logic [CFG_ADDR_W-1:0] REG_GRID_WIDTH  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_GRID_HEIGHT = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_GRID_DEPTH  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_PERIODIC    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_SCHEME      = 3'd4;

  localparam logic SCHEME_FACE = 1'b0;
  localparam logic SCHEME_ALL  = 1'b1;

  // step codes along one axis
  localparam logic [1:0] D_M = 2'd0;
  localparam logic [1:0] D_Z = 2'd1;
  localparam logic [1:0] D_P = 2'd2;

  typedef struct packed {
    logic [1:0] dz;
    logic [1:0] dy;
    logic [1:0] dx;
  } delta_t;

  typedef struct packed {
    logic lo;
    logic hi;
    logic ok_m;
    logic ok_p;
  } axis_t;

  typedef struct packed {
    axis_t z;
    axis_t y;
    axis_t x;
  } axes_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [DIM_W-1:0] col;
  } tag_t;

  localparam delta_t ALL_TAB [SLOT_N] = '{
    '{D_M, D_M, D_M}, '{D_M, D_M, D_Z}, '{D_M, D_M, D_P},
    '{D_M, D_Z, D_M}, '{D_M, D_Z, D_Z}, '{D_M, D_Z, D_P},
    '{D_M, D_P, D_M}, '{D_M, D_P, D_Z}, '{D_M, D_P, D_P},
    '{D_Z, D_M, D_M}, '{D_Z, D_M, D_Z}, '{D_Z, D_M, D_P},
    '{D_Z, D_Z, D_M},                   '{D_Z, D_Z, D_P},
    '{D_Z, D_P, D_M}, '{D_Z, D_P, D_Z}, '{D_Z, D_P, D_P},
    '{D_P, D_M, D_M}, '{D_P, D_M, D_Z}, '{D_P, D_M, D_P},
    '{D_P, D_Z, D_M}, '{D_P, D_Z, D_Z}, '{D_P, D_Z, D_P},
    '{D_P, D_P, D_M}, '{D_P, D_P, D_Z}, '{D_P, D_P, D_P}
  };

  // -x, +x, -y, +y, -z, +z
  localparam delta_t FACE_TAB [FACE_N] = '{
    '{D_Z, D_Z, D_M}, '{D_Z, D_Z, D_P},
    '{D_Z, D_M, D_Z}, '{D_Z, D_P, D_Z},
    '{D_M, D_Z, D_Z}, '{D_P, D_Z, D_Z}
  };

  function automatic logic slot_used(input logic scheme, input logic [SLOT_W-1:0] slot);
    logic u;
    if (scheme == SCHEME_ALL) begin
      u = (slot < SLOT_W'(SLOT_N));
    end else begin
      u = (slot < SLOT_W'(FACE_N));
    end
    return u;
  endfunction

  function automatic delta_t slot_delta(input logic scheme, input logic [SLOT_W-1:0] slot);
    delta_t d;
    d = '{D_Z, D_Z, D_Z};
    if (scheme == SCHEME_ALL) begin
      if (slot < SLOT_W'(SLOT_N)) d = ALL_TAB[slot];
    end else if (slot < SLOT_W'(FACE_N)) begin
      d = FACE_TAB[slot[FACE_W-1:0]];
    end
    return d;
  endfunction

  function automatic axis_t axis_flags(input logic lo, input logic hi, input logic can_wrap);
    axis_t a;
    a.lo   = lo;
    a.hi   = hi;
    a.ok_m = !lo || can_wrap;
    a.ok_p = !hi || can_wrap;
    return a;
  endfunction

  function automatic logic axis_ok(input logic [1:0] code, input axis_t a);
    logic ok;
    case (code)
      D_M:     ok = a.ok_m;
      D_P:     ok = a.ok_p;
      default: ok = 1'b1;
    endcase
    return ok;
  endfunction

  function automatic logic axis_wrap(input logic [1:0] code, input axis_t a);
    return ((code == D_M) && a.lo) || ((code == D_P) && a.hi);
  endfunction

  // linear offset of one axis step; unit is the axis stride, span is (extent-1)*stride
  function automatic logic signed [OFS_W-1:0] axis_ofs(input logic [1:0] code,
                                                       input axis_t a,
                                                       input logic [VOL_W-1:0] unit,
                                                       input logic [VOL_W-1:0] span);
    logic signed [OFS_W-1:0] u;
    logic signed [OFS_W-1:0] s;
    logic signed [OFS_W-1:0] o;
    u = $signed({2'b00, unit});
    s = $signed({2'b00, span});
    case (code)
      D_M:     o = a.lo ? s : -u;
      D_P:     o = a.hi ? -s : u;
      default: o = '0;
    endcase
    return o;
  endfunction

endpackage

// File: src/grid_neighbor_index_generator.sv
// ----------------------------------------------------------------------------
// Grid neighbour index generator
// Splits a linear voxel index into column, row and plane and streams out the
// linear indices of its face (6) or face/edge/vertex (26) neighbours.
// ----------------------------------------------------------------------------
// An input transaction is taken into a pipeline of two dividers (15 stages
// each, two quotient bits per stage) followed by a flag stage and a mask
// stage; it then waits in the emitter, which sends one result per cycle while
// the output is not stalled, through two offset/add stages and the output
// register. An item stays in the emitter for one result per neighbour (one
// result when it has none or lies outside the volume): at most 6 in the face
// scheme, 26 in the full scheme. Throughput is set by that emitter. Extents
// of 0 read as 1 and extents above MAX_DIM saturate. The user must write
// the registers only while no transaction is in flight; the block itself
// does not enforce this.
// ----------------------------------------------------------------------------
module grid_neighbor_index_generator #(
  parameter int MAX_DIM = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_wr_en,
  input  logic [gnig_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [gnig_pkg::DIM_W-1:0]         cfg_wdata,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [gnig_pkg::IN_TDATA_W-1:0]    in_tdata,   // [29:0] voxel_index
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [gnig_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [29:0] neighbor_index
  output logic [gnig_pkg::OUT_TUSER_W-1:0]   out_tuser,  // [0] wrapped [1] valid_res [2] bad_index
  output logic                               out_tlast
);
  import gnig_pkg::*;

  // configuration registers
  logic [DIM_W-1:0] grid_width_r, grid_height_r, grid_depth_r;
  logic             periodic_mode_r, neighbor_scheme_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r      <= DIM_W'(1);
      grid_height_r     <= DIM_W'(1);
      grid_depth_r      <= DIM_W'(1);
      periodic_mode_r   <= 1'b0;
      neighbor_scheme_r <= SCHEME_FACE;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_GRID_WIDTH:  grid_width_r      <= cfg_wdata;
        REG_GRID_HEIGHT: grid_height_r     <= cfg_wdata;
        REG_GRID_DEPTH:  grid_depth_r      <= cfg_wdata;
        REG_PERIODIC:    periodic_mode_r   <= cfg_wdata[0];
        REG_SCHEME:      neighbor_scheme_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] e;
    if (v == '0) begin
      e = DIM_W'(1);
    end else if (32'(v) > 32'(MAX_DIM)) begin
      e = DIM_W'(MAX_DIM);
    end else begin
      e = v;
    end
    return e;
  endfunction

  logic [DIM_W-1:0] w_eff, h_eff, d_eff, wm1;
  assign w_eff = eff_dim(grid_width_r);
  assign h_eff = eff_dim(grid_height_r);
  assign d_eff = eff_dim(grid_depth_r);
  assign wm1   = w_eff - DIM_W'(1);

  // derived strides: slice_r and hm1w_r, then vol_r, then dm1s_r, registered in turn after a register write
  logic [SLICE_W-1:0] slice_r, hm1w_r;
  logic [VOL_W-1:0]   vol_r, dm1s_r;

  always_ff @(posedge clk) begin
    slice_r <= SLICE_W'(w_eff) * SLICE_W'(h_eff);
    hm1w_r  <= SLICE_W'(h_eff - DIM_W'(1)) * SLICE_W'(w_eff);
    vol_r   <= VOL_W'(slice_r) * VOL_W'(d_eff);
    dm1s_r  <= vol_r - VOL_W'(slice_r);
  end

  // flow control
  logic adv, load, front_go;
  logic out_valid_r;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = front_go;

  // division: index / width, then quotient / height
  logic             d1_valid, d2_valid;
  logic [IDX_W-1:0] d1_quot, d2_quot;
  logic [DIM_W-1:0] d1_rem, d2_rem;
  tag_t             d1_tag, d2_tag;
  tag_t             d1_tag_in, d2_tag_in;

  assign d1_tag_in.idx = in_tdata[IDX_W-1:0];
  assign d1_tag_in.col = '0;
  assign d2_tag_in.idx = d1_tag.idx;
  assign d2_tag_in.col = d1_rem;

  gnig_div_pipe u_div_col (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (front_go),
    .in_valid  (in_tvalid),
    .in_num    (in_tdata[IDX_W-1:0]),
    .in_den    (w_eff),
    .in_tag    (d1_tag_in),
    .out_valid (d1_valid),
    .out_quot  (d1_quot),
    .out_rem   (d1_rem),
    .out_tag   (d1_tag)
  );

  gnig_div_pipe u_div_row (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (front_go),
    .in_valid  (d1_valid),
    .in_num    (d1_quot),
    .in_den    (h_eff),
    .in_tag    (d2_tag_in),
    .out_valid (d2_valid),
    .out_quot  (d2_quot),
    .out_rem   (d2_rem),
    .out_tag   (d2_tag)
  );

  // boundary flags
  logic             f_valid_r, f_bad_r;
  logic [IDX_W-1:0] f_idx_r;
  axes_t            f_ax_r, f_ax_nxt;

  always_comb begin
    f_ax_nxt.x = axis_flags(d2_tag.col == '0, d2_tag.col == wm1,
                            periodic_mode_r && (w_eff != DIM_W'(1)));
    f_ax_nxt.y = axis_flags(d2_rem == '0, d2_rem == h_eff - DIM_W'(1),
                            periodic_mode_r && (h_eff != DIM_W'(1)));
    f_ax_nxt.z = axis_flags(d2_quot == '0, d2_quot == IDX_W'(d_eff - DIM_W'(1)),
                            periodic_mode_r && (d_eff != DIM_W'(1)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (front_go) begin
      f_valid_r <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (front_go) begin
      f_idx_r <= d2_tag.idx;
      f_bad_r <= VOL_W'(d2_tag.idx) >= vol_r;
      f_ax_r  <= f_ax_nxt;
    end
  end

  // neighbour mask in emission order
  logic              g_valid_r, g_bad_r;
  logic [IDX_W-1:0]  g_idx_r;
  axes_t             g_ax_r;
  logic [SLOT_N-1:0] g_mask_r, g_mask_nxt;

  always_comb begin
    delta_t sd;
    for (int s = 0; s < SLOT_N; s++) begin
      sd            = slot_delta(neighbor_scheme_r, SLOT_W'(s));
      g_mask_nxt[s] = !f_bad_r
                   && slot_used(neighbor_scheme_r, SLOT_W'(s))
                   && axis_ok(sd.dx, f_ax_r.x)
                   && axis_ok(sd.dy, f_ax_r.y)
                   && axis_ok(sd.dz, f_ax_r.z);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_valid_r <= 1'b0;
    end else if (front_go) begin
      g_valid_r <= f_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (front_go) begin
      g_idx_r  <= f_idx_r;
      g_bad_r  <= f_bad_r;
      g_ax_r   <= f_ax_r;
      g_mask_r <= g_mask_nxt;
    end
  end

  // emitter: one result per cycle while the output is not stalled, lowest remaining slot first
  logic              em_valid_r, em_bad_r;
  logic [IDX_W-1:0]  em_idx_r;
  axes_t             em_ax_r;
  logic [SLOT_N-1:0] em_mask_r, em_mask_nxt;
  logic [SLOT_W-1:0] slot_sel;
  logic              em_any, em_last;
  delta_t            em_delta;

  always_comb begin
    slot_sel = '0;
    for (int s = SLOT_N - 1; s >= 0; s--) begin
      if (em_mask_r[s]) slot_sel = SLOT_W'(s);
    end
  end

  assign em_mask_nxt = em_mask_r & ~(SLOT_N'(1) << slot_sel);
  assign em_any      = |em_mask_r;
  assign em_last     = (em_mask_nxt == '0);
  assign em_delta    = slot_delta(neighbor_scheme_r, slot_sel);
  assign load        = adv && (!em_valid_r || em_last);
  assign front_go    = !g_valid_r || load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_valid_r <= 1'b0;
    end else if (load) begin
      em_valid_r <= g_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      em_idx_r  <= g_idx_r;
      em_bad_r  <= g_bad_r;
      em_ax_r   <= g_ax_r;
      em_mask_r <= g_mask_r;
    end else if (adv && em_valid_r) begin
      em_mask_r <= em_mask_nxt;
    end
  end

  // offset stage
  logic                    o1_valid_r, o1_wrap_r, o1_res_r, o1_bad_r, o1_last_r;
  logic [IDX_W-1:0]        o1_idx_r;
  logic signed [OFS_W-1:0] o1_ox_r, o1_oy_r, o1_oz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o1_valid_r <= 1'b0;
    end else if (adv) begin
      o1_valid_r <= em_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o1_idx_r  <= em_any ? em_idx_r : '0;
      o1_res_r  <= em_any;
      o1_bad_r  <= em_bad_r;
      o1_last_r <= em_last;
      o1_wrap_r <= em_any && (axis_wrap(em_delta.dx, em_ax_r.x)
                           || axis_wrap(em_delta.dy, em_ax_r.y)
                           || axis_wrap(em_delta.dz, em_ax_r.z));
      if (em_any) begin
        o1_ox_r <= axis_ofs(em_delta.dx, em_ax_r.x, VOL_W'(1), VOL_W'(wm1));
        o1_oy_r <= axis_ofs(em_delta.dy, em_ax_r.y, VOL_W'(w_eff), VOL_W'(hm1w_r));
        o1_oz_r <= axis_ofs(em_delta.dz, em_ax_r.z, VOL_W'(slice_r), dm1s_r);
      end else begin
        o1_ox_r <= '0;
        o1_oy_r <= '0;
        o1_oz_r <= '0;
      end
    end
  end

  // partial sums
  logic                    o2_valid_r, o2_wrap_r, o2_res_r, o2_bad_r, o2_last_r;
  logic signed [OFS_W-1:0] o2_s1_r, o2_s2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o2_valid_r <= 1'b0;
    end else if (adv) begin
      o2_valid_r <= o1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o2_s1_r   <= $signed(OFS_W'(o1_idx_r)) + o1_oz_r;
      o2_s2_r   <= o1_ox_r + o1_oy_r;
      o2_wrap_r <= o1_wrap_r;
      o2_res_r  <= o1_res_r;
      o2_bad_r  <= o1_bad_r;
      o2_last_r <= o1_last_r;
    end
  end

  // output register
  logic [OFS_W-1:0] sum_nxt;
  logic [IDX_W-1:0] out_idx_r;
  logic             out_wrap_r, out_res_r, out_bad_r, out_last_r;

  assign sum_nxt = o2_s1_r + o2_s2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= o2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_idx_r  <= sum_nxt[IDX_W-1:0];
      out_wrap_r <= o2_wrap_r;
      out_res_r  <= o2_res_r;
      out_bad_r  <= o2_bad_r;
      out_last_r <= o2_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - IDX_W){1'b0}}, out_idx_r};
  assign out_tuser  = {out_bad_r, out_res_r, out_wrap_r};
  assign out_tlast  = out_last_r;

  `include "grid_neighbor_index_generator_assert.svh"

  `GNIG_ASSERT_IMP(a_bad_is_lone, out_tvalid && out_tuser[2], !out_tuser[1] && out_tlast,
                   "out-of-volume transaction must be a single invalid result")
  `GNIG_ASSERT_IMP(a_wrap_needs_periodic, out_tvalid && out_tuser[0], periodic_mode_r,
                   "wrapped result outside periodic mode")
  `GNIG_ASSERT_NXT(a_mask_only_clears, em_valid_r && !load,
                   (em_mask_r & ~$past(em_mask_r)) == '0, "emitter mask gained a slot")
  `GNIG_ASSERT_IMP(a_face_slots_only, em_valid_r && (neighbor_scheme_r == SCHEME_FACE),
                   em_mask_r[SLOT_N-1:FACE_N] == '0, "face scheme with slot beyond six")

endmodule

// File: src/gnig_div_pipe.sv
// ----------------------------------------------------------------------------
// Grid neighbour index generator - pipelined divider
// Restoring division of an index by a grid extent, STEP_N quotient bits per
// stage, with a sideband tag carried alongside.
// ----------------------------------------------------------------------------
module gnig_div_pipe (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [gnig_pkg::IDX_W-1:0]  in_num,
  input  logic [gnig_pkg::DIM_W-1:0]  in_den,
  input  gnig_pkg::tag_t              in_tag,
  output logic                        out_valid,
  output logic [gnig_pkg::IDX_W-1:0]  out_quot,
  output logic [gnig_pkg::DIM_W-1:0]  out_rem,
  output gnig_pkg::tag_t              out_tag
);
  import gnig_pkg::*;

  logic [DIV_STAGES-1:0] valid_r;
  logic [DIM_W:0]        a_r   [DIV_STAGES];
  logic [IDX_W-1:0]      q_r   [DIV_STAGES];
  tag_t                  tag_r [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic             v_in;
    logic [DIM_W:0]   a_in;
    logic [IDX_W-1:0] q_in;
    tag_t             tag_in;
    logic [DIM_W:0]   a_nxt;
    logic [IDX_W-1:0] q_nxt;

    if (s == 0) begin : g_head
      assign v_in   = in_valid;
      assign a_in   = '0;
      assign q_in   = in_num;
      assign tag_in = in_tag;
    end else begin : g_body
      assign v_in   = valid_r[s-1];
      assign a_in   = a_r[s-1];
      assign q_in   = q_r[s-1];
      assign tag_in = tag_r[s-1];
    end

    always_comb begin
      a_nxt = a_in;
      q_nxt = q_in;
      for (int k = 0; k < STEP_N; k++) begin
        a_nxt = {a_nxt[DIM_W-1:0], q_nxt[IDX_W-1]};
        q_nxt = {q_nxt[IDX_W-2:0], 1'b0};
        if (a_nxt >= {1'b0, in_den}) begin
          a_nxt    = a_nxt - {1'b0, in_den};
          q_nxt[0] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[s] <= 1'b0;
      end else if (en) begin
        valid_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_r[s]   <= a_nxt;
        q_r[s]   <= q_nxt;
        tag_r[s] <= tag_in;
      end
    end
  end

  assign out_valid = valid_r[DIV_STAGES-1];
  assign out_quot  = q_r[DIV_STAGES-1];
  assign out_rem   = a_r[DIV_STAGES-1][DIM_W-1:0];
  assign out_tag   = tag_r[DIV_STAGES-1];

endmodule
